[rtl/iso_pkg.sv]
// ----------------------------------------------------------------------------
// iso_pkg
// Shared types, character codes, layout tables and calendar constants for the
// timestamp text to epoch seconds parser.
// ----------------------------------------------------------------------------
package iso_pkg;

   localparam int unsigned POS_W      = 5;
   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned FIELD_W    = 7;
   localparam int unsigned EPOCH_W    = 39;
   localparam int unsigned CNT_W      = 3;

   localparam logic [POS_W-1:0] POS_TAIL  = 5'd19;
   localparam logic [CNT_W-1:0] CONV_LAST = 3'd4;

   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z     = 8'h5a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_NONE  = 8'h00;

   localparam logic [2:0] FLD_YEAR   = 3'd0;
   localparam logic [2:0] FLD_MONTH  = 3'd1;
   localparam logic [2:0] FLD_DAY    = 3'd2;
   localparam logic [2:0] FLD_HOUR   = 3'd3;
   localparam logic [2:0] FLD_MINUTE = 3'd4;
   localparam logic [2:0] FLD_SECOND = 3'd5;

   localparam logic signed [24:0] ERA_DAYS    = 25'sd146097;
   localparam logic signed [24:0] SHIFT_DAYS  = 25'sd719468;
   localparam logic signed [42:0] SEC_PER_DAY = 43'sd86400;

   typedef enum logic [1:0] {
      TAIL_WAIT = 2'd0,
      TAIL_DOT  = 2'd1,
      TAIL_FRAC = 2'd2,
      TAIL_DONE = 2'd3
   } tail_type;

   typedef enum logic [1:0] {
      ST_SCAN   = 2'd0,
      ST_CONV   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic scan_en;
      logic capture;
      logic load_out;
   } cmd_type;

   function automatic logic [7:0] sep_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         5'd4, 5'd7:   c = CH_DASH;
         5'd10:        c = CH_T;
         5'd13, 5'd16: c = CH_COLON;
         default:      c = CH_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] field_sel(input logic [POS_W-1:0] pos);
      logic [2:0] f;
      case (pos)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4: f = FLD_YEAR;
         5'd5, 5'd6, 5'd7:             f = FLD_MONTH;
         5'd8, 5'd9, 5'd10:            f = FLD_DAY;
         5'd11, 5'd12, 5'd13:          f = FLD_HOUR;
         5'd14, 5'd15, 5'd16:          f = FLD_MINUTE;
         default:                      f = FLD_SECOND;
      endcase
      return f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         4'd2:                      n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

   // day of a march-based year at which each month starts
   function automatic logic [8:0] doy_base(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[rtl/iso_ctrl.sv]
// ----------------------------------------------------------------------------
// iso_ctrl
// Controller: byte scanning, conversion step count and result handshake.
// ----------------------------------------------------------------------------
module iso_ctrl
   import iso_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_is_final,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_SCAN: begin
            req_ready   = 1'b1;
            cmd.scan_en = req_valid;
            cmd.capture = req_valid && req_is_final;
            if (cmd.capture) begin
               state_in = ST_CONV;
               cnt_in   = '0;
            end
         end
         ST_CONV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CONV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/iso_dp.sv]
// ----------------------------------------------------------------------------
// iso_dp
// Datapath: character checks, field accumulation, calendar conversion stages
// and the result register.
// ----------------------------------------------------------------------------
module iso_dp
   import iso_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic [7:0]                req_text_byte,
   output logic                      rsp_valid_res,
   output logic signed [EPOCH_W-1:0] rsp_unix_secs
);

   // scanner state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in, day_ff, day_in;
   logic [FIELD_W-1:0] hour_ff, hour_in, minute_ff, minute_in, second_ff, second_in;
   tail_type           tail_ff, tail_in;
   logic               err_ff, err_in;

   // captured fields
   logic [YEAR_W-1:0]  cyear_ff;
   logic [FIELD_W-1:0] cmonth_ff, cday_ff, chour_ff, cminute_ff, csecond_ff;
   logic               cfmt_ff;

   // conversion stages
   logic               neg_ff;
   logic [YEAR_W-1:0]  yu_ff;
   logic [5:0]         q400_ff;
   logic [7:0]         q100_ff;
   logic [18:0]        hms_ff;
   logic signed [6:0]  era_ff;
   logic [8:0]         yoe_ff;
   logic               valid_ff;
   logic signed [24:0] e146_ff;
   logic [17:0]        y365_ff;
   logic [6:0]         yq4_ff;
   logic [2:0]         yq100_ff;
   logic signed [24:0] days_ff;
   logic [EPOCH_W-1:0] prod_ff;
   logic               res_valid_ff;
   logic [EPOCH_W-1:0] res_epoch_ff;

   logic [7:0]  sep;
   logic [3:0]  dig;
   logic [17:0] year_acc;
   logic [10:0] month_acc, day_acc, hour_acc, minute_acc, second_acc;

   always_comb begin
      pos_in    = pos_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      tail_in   = tail_ff;
      err_in    = err_ff;
      sep       = sep_char(pos_ff);
      dig       = 4'(req_text_byte - CH_ZERO);
      year_acc   = 18'(year_ff) * 18'd10 + 18'(dig);
      month_acc  = 11'(month_ff) * 11'd10 + 11'(dig);
      day_acc    = 11'(day_ff) * 11'd10 + 11'(dig);
      hour_acc   = 11'(hour_ff) * 11'd10 + 11'(dig);
      minute_acc = 11'(minute_ff) * 11'd10 + 11'(dig);
      second_acc = 11'(second_ff) * 11'd10 + 11'(dig);
      if (!err_ff) begin
         if (pos_ff < POS_TAIL) begin
            pos_in = pos_ff + 1'b1;
            if (sep != CH_NONE) begin
               if (req_text_byte != sep) begin
                  err_in = 1'b1;
               end
            end else if (is_digit(req_text_byte)) begin
               case (field_sel(pos_ff))
                  FLD_YEAR:   year_in   = year_acc[YEAR_W-1:0];
                  FLD_MONTH:  month_in  = month_acc[FIELD_W-1:0];
                  FLD_DAY:    day_in    = day_acc[FIELD_W-1:0];
                  FLD_HOUR:   hour_in   = hour_acc[FIELD_W-1:0];
                  FLD_MINUTE: minute_in = minute_acc[FIELD_W-1:0];
                  default:    second_in = second_acc[FIELD_W-1:0];
               endcase
            end else begin
               err_in = 1'b1;
            end
         end else begin
            case (tail_ff)
               TAIL_WAIT: begin
                  if (req_text_byte == CH_DOT) begin
                     tail_in = TAIL_DOT;
                  end else if (req_text_byte == CH_Z) begin
                     tail_in = TAIL_DONE;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               TAIL_DOT: begin
                  if (is_digit(req_text_byte)) begin
                     tail_in = TAIL_FRAC;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               TAIL_FRAC: begin
                  if (req_text_byte == CH_Z) begin
                     tail_in = TAIL_DONE;
                  end else if (!is_digit(req_text_byte)) begin
                     err_in = 1'b1;
                  end
               end
               default: begin
                  err_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         pos_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         tail_ff   <= TAIL_WAIT;
         err_ff    <= 1'b0;
      end else if (cmd.scan_en) begin
         pos_ff    <= pos_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         tail_ff   <= tail_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cyear_ff   <= year_in;
         cmonth_ff  <= month_in;
         cday_ff    <= day_in;
         chour_ff   <= hour_in;
         cminute_ff <= minute_in;
         csecond_ff <= second_in;
         cfmt_ff    <= !err_in && (tail_in == TAIL_DONE);
      end
   end

   // stage 1: year split by reciprocal multiplication, time of day
   logic        early;
   logic [13:0] yu;
   logic [26:0] q400_prod;
   logic [28:0] q100_prod;

   always_comb begin
      early     = (cmonth_ff <= 7'd2);
      yu        = cyear_ff - 14'(early);
      q400_prod = 27'(yu) * 27'd5243;
      q100_prod = 29'(cyear_ff) * 29'd20972;
   end

   always_ff @(posedge clock) begin
      neg_ff  <= early && (cyear_ff == '0);
      yu_ff   <= yu;
      q400_ff <= q400_prod[26:21];
      q100_ff <= q100_prod[28:21];
      hms_ff  <= 19'(chour_ff) * 19'd3600 + 19'(cminute_ff) * 19'd60 + 19'(csecond_ff);
   end

   // stage 2: era, year of era, range checks
   logic [14:0] q400x;
   logic [14:0] q100x;
   logic        leap;
   logic [4:0]  mdays;

   always_comb begin
      q400x = 15'(q400_ff) * 15'd400;
      q100x = 15'(q100_ff) * 15'd100;
      leap  = (cyear_ff[1:0] == 2'd0) &&
              ((15'(cyear_ff) != q100x) || (q100_ff[1:0] == 2'd0));
      mdays = month_len(cmonth_ff[3:0], leap);
   end

   always_ff @(posedge clock) begin
      era_ff   <= neg_ff ? -7'sd1 : $signed({1'b0, q400_ff});
      yoe_ff   <= neg_ff ? 9'd399 : 9'(15'(yu_ff) - q400x);
      valid_ff <= cfmt_ff &&
                  (cmonth_ff >= 7'd1) && (cmonth_ff <= 7'd12) &&
                  (cday_ff >= 7'd1) && (cday_ff <= 7'(mdays)) &&
                  (chour_ff <= 7'd23) && (cminute_ff <= 7'd59) &&
                  (csecond_ff <= 7'd60);
   end

   // stage 3: era and year-of-era day counts
   logic [18:0] yq100_prod;

   assign yq100_prod = 19'(yoe_ff) * 19'd656;

   always_ff @(posedge clock) begin
      e146_ff  <= 25'(era_ff) * ERA_DAYS;
      y365_ff  <= 18'(yoe_ff) * 18'd365;
      yq4_ff   <= yoe_ff[8:2];
      yq100_ff <= yq100_prod[18:16];
   end

   // stage 4: day number relative to 1970-01-01
   logic [8:0] doy;

   assign doy = doy_base(cmonth_ff[3:0]) + 9'(cday_ff) - 9'd1;

   always_ff @(posedge clock) begin
      days_ff <= e146_ff + $signed(25'(y365_ff)) + $signed(25'(yq4_ff))
               - $signed(25'(yq100_ff)) + $signed(25'(doy)) - SHIFT_DAYS;
   end

   // stage 5: day number to seconds
   logic signed [42:0] prod;

   assign prod = 43'(days_ff) * SEC_PER_DAY;

   always_ff @(posedge clock) begin
      prod_ff <= prod[EPOCH_W-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         res_valid_ff <= valid_ff;
         res_epoch_ff <= valid_ff ? (prod_ff + EPOCH_W'(hms_ff)) : '0;
      end
   end

   assign rsp_valid_res = res_valid_ff;
   assign rsp_unix_secs = $signed(res_epoch_ff);

endmodule

[rtl/iso8601_utc_to_epoch_parser_top.sv]
// result: shown after the final byte once the calendar conversion is done, later if
// the previous result is still waiting in the output register
// throughput: one text byte per cycle while scanning; after the final byte the input
// stalls while the five-step calendar conversion runs and the result waits to load
// reset: synchronous, clears the parser and drops any pending result
// ----------------------------------------------------------------------------
// iso8601_utc_to_epoch_parser_top
// Parses timestamp text bytes into a valid flag and Unix epoch seconds.
// ----------------------------------------------------------------------------
module iso8601_utc_to_epoch_parser_top
   import iso_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_text_byte,
   input  logic                      req_is_final,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_valid_res,
   output logic signed [EPOCH_W-1:0] rsp_unix_secs
);

   cmd_type cmd;

   iso_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_final (req_is_final),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd)
   );

   iso_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_text_byte (req_text_byte),
      .rsp_valid_res (rsp_valid_res),
      .rsp_unix_secs (rsp_unix_secs)
   );

endmodule

[rtl/iso_chk.sv]
// ----------------------------------------------------------------------------
// iso_chk
// Port-level checks for the timestamp parser, bound to the top level.
// ----------------------------------------------------------------------------
module iso_chk
   import iso_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_is_final,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_valid_res,
   input logic signed [EPOCH_W-1:0] rsp_unix_secs
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_valid_res) && $stable(rsp_unix_secs))
      else $error("result changed while stalled");

   // an invalid result carries zero seconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_unix_secs == '0)
      else $error("invalid result with nonzero seconds");

   // input stalls while the conversion runs
   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_final |=>
         !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("byte taken during conversion");

   // a new result only appears at the end of a conversion
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without conversion");

endmodule

bind iso8601_utc_to_epoch_parser_top iso_chk u_iso_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_is_final  (req_is_final),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_valid_res (rsp_valid_res),
   .rsp_unix_secs (rsp_unix_secs)
);

[bench/tb_iso8601_utc_to_epoch_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_iso8601_utc_to_epoch_parser_top
// Streams timestamp text, one character per transfer, into the parser. A
// local scanner follows the same character layout and calendar math to
// predict each result, and the monitor checks every result transfer against
// the oldest prediction. The sender works in bursts with random gaps. The
// receiver stalls on patterns of its own, with long hold-offs that back the
// parser up into its input.
// ----------------------------------------------------------------------------
module tb_iso8601_utc_to_epoch_parser_top;
   import iso_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
   } text_item_type;

   typedef struct packed {
      logic                      valid_res;
      logic signed [EPOCH_W-1:0] unix_secs;
   } epoch_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_text_byte = 8'd0;
   logic                      req_is_final = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_valid_res;
   logic signed [EPOCH_W-1:0] rsp_unix_secs;

   text_item_type    pending_text[$];
   logic [7:0]       text_buf[$];
   epoch_result_type epoch_results_due[$];

   // scanner state
   logic [POS_W-1:0]   text_pos;
   logic [YEAR_W-1:0]  year_acc;
   logic [FIELD_W-1:0] month_acc, day_acc, hour_acc, minute_acc, second_acc;
   tail_type           tail_state;
   logic               shape_bad;

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  rx_tick = 0;
   int  rx_mode = 0;
   logic hold_rsp = 1'b0;

   iso8601_utc_to_epoch_parser_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_valid_res (rsp_valid_res),
      .rsp_unix_secs (rsp_unix_secs)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit digit_char(input logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic int mdays_of(input int yr, input int mo);
      bit leap;
      leap = (yr % 4 == 0 && yr % 100 != 0) || (yr % 400 == 0);
      case (mo)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic longint day_number(input int yr, input int mo, input int dy);
      longint y, era, yoe, mp, doy, doe;
      y   = yr - ((mo <= 2) ? 1 : 0);
      era = ((y >= 0) ? y : y - 399) / 400;
      yoe = y - era * 400;
      mp  = (mo > 2) ? mo - 3 : mo + 9;
      doy = (153 * mp + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   task automatic clear_scanner();
      text_pos   = '0;
      year_acc   = '0;
      month_acc  = '0;
      day_acc    = '0;
      hour_acc   = '0;
      minute_acc = '0;
      second_acc = '0;
      tail_state = TAIL_WAIT;
      shape_bad  = 1'b0;
   endtask

   task automatic scan_text_byte(input logic [7:0] ch, input logic final_byte);
      logic [7:0]       sep;
      logic [3:0]       dval;
      bit               ok;
      longint           secs;
      epoch_result_type res;
      if (!shape_bad) begin
         if (text_pos < POS_TAIL) begin
            case (text_pos)
               5'd4, 5'd7:   sep = CH_DASH;
               5'd10:        sep = CH_T;
               5'd13, 5'd16: sep = CH_COLON;
               default:      sep = CH_NONE;
            endcase
            if (sep != CH_NONE) begin
               if (ch != sep) shape_bad = 1'b1;
            end else if (digit_char(ch)) begin
               dval = ch - CH_ZERO;
               case (text_pos)
                  5'd0, 5'd1, 5'd2, 5'd3: year_acc   = year_acc * 10 + dval;
                  5'd5, 5'd6:             month_acc  = month_acc * 10 + dval;
                  5'd8, 5'd9:             day_acc    = day_acc * 10 + dval;
                  5'd11, 5'd12:           hour_acc   = hour_acc * 10 + dval;
                  5'd14, 5'd15:           minute_acc = minute_acc * 10 + dval;
                  default:                second_acc = second_acc * 10 + dval;
               endcase
            end else begin
               shape_bad = 1'b1;
            end
            text_pos = text_pos + 1'b1;
         end else begin
            case (tail_state)
               TAIL_WAIT: begin
                  if (ch == CH_DOT) tail_state = TAIL_DOT;
                  else if (ch == CH_Z) tail_state = TAIL_DONE;
                  else shape_bad = 1'b1;
               end
               TAIL_DOT: begin
                  if (digit_char(ch)) tail_state = TAIL_FRAC;
                  else shape_bad = 1'b1;
               end
               TAIL_FRAC: begin
                  if (ch == CH_Z) tail_state = TAIL_DONE;
                  else if (!digit_char(ch)) shape_bad = 1'b1;
               end
               default: shape_bad = 1'b1;
            endcase
         end
      end
      if (final_byte) begin
         ok = !shape_bad && tail_state == TAIL_DONE;
         if (ok && (month_acc < 1 || month_acc > 12)) ok = 1'b0;
         if (ok && (day_acc < 1 || day_acc > mdays_of(year_acc, month_acc))) ok = 1'b0;
         if (ok && (hour_acc > 23 || minute_acc > 59 || second_acc > 60)) ok = 1'b0;
         secs = 0;
         if (ok)
            secs = day_number(year_acc, month_acc, day_acc) * 86400
                 + longint'(hour_acc) * 3600 + longint'(minute_acc) * 60
                 + longint'(second_acc);
         res.valid_res = ok;
         res.unix_secs = secs[EPOCH_W-1:0];
         epoch_results_due.push_back(res);
         clear_scanner();
      end
   endtask

   // stimulus building
   task automatic flush_text();
      text_item_type it;
      for (int i = 0; i < text_buf.size(); i++) begin
         it.text_byte = text_buf[i];
         it.is_final  = (i == text_buf.size() - 1);
         pending_text.push_back(it);
      end
      text_buf.delete();
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      flush_text();
   endtask

   task automatic push_num(input int v, input int n);
      int div;
      div = 1;
      for (int i = 1; i < n; i++) div = div * 10;
      for (int i = 0; i < n; i++) begin
         text_buf.push_back(CH_ZERO + (v / div) % 10);
         div = div / 10;
      end
   endtask

   task automatic build_timestamp(input int yr, input int mo, input int dy, input int hr,
                                  input int mi, input int se, input int frac_len);
      push_num(yr, 4);
      text_buf.push_back(CH_DASH);
      push_num(mo, 2);
      text_buf.push_back(CH_DASH);
      push_num(dy, 2);
      text_buf.push_back(CH_T);
      push_num(hr, 2);
      text_buf.push_back(CH_COLON);
      push_num(mi, 2);
      text_buf.push_back(CH_COLON);
      push_num(se, 2);
      if (frac_len > 0) begin
         text_buf.push_back(CH_DOT);
         for (int i = 0; i < frac_len; i++) text_buf.push_back(CH_ZERO + $urandom_range(0, 9));
      end
      text_buf.push_back(CH_Z);
   endtask

   initial begin
      int kind, yr, mo, dy, hr, mi, se, n, target;
      add_string("1970-01-01T00:00:00Z");
      add_string("0000-01-01T00:00:00Z");
      add_string("9999-12-31T23:59:60Z");
      add_string("2000-02-29T12:30:45.123Z");
      add_string("1900-02-29T00:00:00Z");
      add_string("2024-02-29T23:59:59.9Z");
      add_string("2023-13-01T00:00:00Z");
      add_string("2023-00-10T00:00:00Z");
      add_string("2023-04-31T00:00:00Z");
      add_string("2023-05-00T00:00:00Z");
      add_string("2023-01-01T24:00:00Z");
      add_string("2023-01-01T00:60:00Z");
      add_string("2023-01-01T00:00:61Z");
      add_string("2023-01-01T00:00:00.Z");
      add_string("2023-01-01T00:00:00");
      add_string("2023-01-01T00:00:00ZZ");
      add_string("2023-01-01X00:00:00Z");
      add_string("202a-01-01T00:00:00Z");
      add_string("Z");
      text_buf.push_back(8'hff);
      flush_text();
      target = 1400;
      while (pending_text.size() < target) begin
         kind = $urandom_range(0, 99);
         yr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) * 100 : $urandom_range(0, 9999);
         mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
         n  = mdays_of(yr, mo);
         case ($urandom_range(0, 9))
            0:       dy = $urandom_range(0, 99);
            1, 2:    dy = n + $urandom_range(0, 1);
            default: dy = $urandom_range(1, n);
         endcase
         hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
         mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
         se = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
         build_timestamp(yr, mo, dy, hr, mi, se,
                         $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
         if (kind >= 94) begin
            text_buf.delete();
            n = $urandom_range(1, 25);
            for (int i = 0; i < n; i++) text_buf.push_back($urandom_range(0, 255));
         end else if (kind >= 90) begin
            text_buf.insert(text_buf.size() - 1, CH_DOT);
         end else if (kind >= 83) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               text_buf.push_back($urandom_range(0, 1) ? CH_Z : $urandom_range(0, 255));
         end else if (kind >= 75) begin
            n = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > n) void'(text_buf.pop_back());
         end else if (kind >= 65) begin
            text_buf[$urandom_range(0, text_buf.size() - 1)] = $urandom_range(0, 255);
         end
         flush_text();
      end
   end

   // driver
   always @(posedge clock) begin
      text_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         clear_scanner();
         epoch_results_due.delete();
      end else begin
         if (req_valid && req_ready) scan_text_byte(req_text_byte, req_is_final);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_text.size() > 0) begin
               it = pending_text.pop_front();
               req_valid     <= 1'b1;
               req_text_byte <= it.text_byte;
               req_is_final  <= it.is_final;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      epoch_result_type exp_res;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (epoch_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected result transfer: valid_res=%0b unix_secs=%0d",
                        $time, rsp_valid_res, rsp_unix_secs);
            end else begin
               exp_res = epoch_results_due.pop_front();
               if (rsp_valid_res !== exp_res.valid_res) begin
                  mismatch_count++;
                  $display("%0t valid_res mismatch: expected %0b, actual %0b",
                           $time, exp_res.valid_res, rsp_valid_res);
               end
               if (rsp_unix_secs !== exp_res.unix_secs) begin
                  mismatch_count++;
                  $display("%0t unix_secs mismatch: expected %0d, actual %0d",
                           $time, exp_res.unix_secs, rsp_unix_secs);
               end
            end
         end
         rx_tick++;
         if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0:       rsp_ready <= !hold_rsp;
            1:       rsp_ready <= !hold_rsp && $urandom_range(0, 1);
            2:       rsp_ready <= !hold_rsp && ($urandom_range(0, 3) == 0);
            default: rsp_ready <= !hold_rsp && (rx_tick % 7 < 2);
         endcase
      end
   end

   // long receiver hold-offs while the sender keeps offering
   initial begin
      while (reset || results_seen < 12) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
      while (results_seen < 45) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_text.size() != 0 || req_valid) @(posedge clock);
      while (epoch_results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && epoch_results_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
